@@ src/assert_macros.svh @@
// assertion helpers for the rpn block
// simulation gets the checks, synthesis gets empty bodies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge out of reset
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("assertion failed");

// condition must never be seen at a clock edge out of reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

@@ src/rpn_pkg.sv @@
`timescale 1ns / 1ps

package rpn_pkg;

  // sizing
  localparam int STACK_DEPTH = 64;
  localparam int FRAC_BITS   = 16;
  localparam int DATA_W      = 32;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int SP_W        = $clog2(STACK_DEPTH + 1);
  localparam int CMD_W       = 3;
  localparam int DEPTH_W     = 7;
  localparam int STATUS_W    = 3;
  localparam int DIV_W       = DATA_W + FRAC_BITS;
  localparam int DIV_CNT_W   = $clog2(DIV_W);
  localparam int ADD_W       = DATA_W + 2;

  typedef logic [CMD_W-1:0]           cmd_t;
  typedef logic [STATUS_W-1:0]        status_t;
  typedef logic [DEPTH_W-1:0]         depth_t;
  typedef logic signed [DATA_W-1:0]   data_t;
  typedef logic [ADDR_W-1:0]          addr_t;

  // command codes
  localparam cmd_t CMD_PUSH = cmd_t'(0);
  localparam cmd_t CMD_ADD  = cmd_t'(1);
  localparam cmd_t CMD_SUB  = cmd_t'(2);
  localparam cmd_t CMD_MUL  = cmd_t'(3);
  localparam cmd_t CMD_DIV  = cmd_t'(4);
  localparam cmd_t CMD_NEG  = cmd_t'(5);

  // status codes
  localparam status_t ST_OK        = status_t'(0);
  localparam status_t ST_UNDERFLOW = status_t'(1);
  localparam status_t ST_FULL      = status_t'(2);
  localparam status_t ST_DIVZERO   = status_t'(3);
  localparam status_t ST_SAT       = status_t'(4);

  // saturation limits
  localparam data_t Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam data_t Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic [2:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_MUL,
    ALU_DIV,
    ALU_NEG
  } alu_op_e;

  // sequencer to arithmetic unit
  typedef struct packed {
    logic    start;
    alu_op_e op;
    data_t   left;
    data_t   right;
  } alu_req_t;

  // arithmetic unit back to sequencer
  typedef struct packed {
    logic  done;
    data_t result;
    logic  sat;
    logic  div_zero;
  } alu_rsp_t;

  // stack memory port
  typedef struct packed {
    logic  we;
    addr_t waddr;
    data_t wdata;
    logic  re;
    addr_t raddr;
  } mem_req_t;

endpackage

@@ src/rpn_cmd_if.sv @@
`timescale 1ns / 1ps

// command word channel
interface rpn_cmd_if;
  logic                valid;
  logic                ready;
  rpn_pkg::cmd_t       command;
  rpn_pkg::data_t      value;

  modport source (output valid, output command, output value, input ready);
  modport sink   (input valid, input command, input value, output ready);
endinterface

@@ src/rpn_res_if.sv @@
`timescale 1ns / 1ps

// result word channel
interface rpn_res_if;
  logic                valid;
  logic                ready;
  rpn_pkg::data_t      top_value;
  rpn_pkg::depth_t     depth;
  rpn_pkg::status_t    status;

  modport source (output valid, output top_value, output depth, output status, input ready);
  modport sink   (input valid, input top_value, input depth, input status, output ready);
endinterface

@@ src/rpn_stack_mem.sv @@
`timescale 1ns / 1ps

module rpn_stack_mem (
  input  logic               clk_i,
  input  rpn_pkg::mem_req_t  mem_req_i,
  output rpn_pkg::data_t     rdata_o
);

  rpn_pkg::data_t mem_q [rpn_pkg::STACK_DEPTH];
  rpn_pkg::data_t rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_req_i.we) begin
      mem_q[mem_req_i.waddr] <= mem_req_i.wdata;
    end
    if (mem_req_i.re) begin
      rdata_q <= mem_q[mem_req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/rpn_alu.sv @@
`timescale 1ns / 1ps

module rpn_alu (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rpn_pkg::alu_req_t  req_i,
  output rpn_pkg::alu_rsp_t  rsp_o
);

  localparam int DW = rpn_pkg::DATA_W;
  localparam int AW = rpn_pkg::ADD_W;
  localparam int QW = rpn_pkg::DIV_W;

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_MUL  = 4'b0010,
    PH_DIV  = 4'b0100,
    PH_FIX  = 4'b1000
  } phase_e;

  phase_e                          phase_q;
  logic [rpn_pkg::DIV_CNT_W-1:0]   cnt_q;
  logic                            done_q;
  logic [DW-1:0]                   rem_q;
  logic [QW-1:0]                   dq_q;
  logic [DW-1:0]                   mb_q;
  logic                            neg_q;
  logic signed [2*DW-1:0]          prod_q;
  rpn_pkg::data_t                  res_q;
  logic                            sat_q;
  logic                            dz_q;

  logic [AW-1:0]                   add_a;
  logic [AW-1:0]                   add_b;
  logic [AW-1:0]                   add_sum;
  logic                            add_sub;
  logic                            add_fits;
  rpn_pkg::data_t                  add_clip;

  logic signed [2*DW-1:0]          mul_sh;
  logic                            mul_fits;
  rpn_pkg::data_t                  mul_clip;

  logic [DW-1:0]                   mag_l;
  logic [DW-1:0]                   mag_r;
  logic                            trial_neg;
  logic [QW:0]                     q_ext;
  logic                            q_sat;

  // shared adder: add, subtract, negate, divider trial step, quotient sign
  always_comb begin
    add_a   = '0;
    add_b   = '0;
    add_sub = 1'b0;
    unique case (phase_q)
      PH_DIV: begin
        add_a   = {1'b0, rem_q, dq_q[QW-1]};
        add_b   = AW'(mb_q);
        add_sub = 1'b1;
      end
      PH_FIX: begin
        add_b   = AW'(dq_q[DW-1:0]);
        add_sub = neg_q;
      end
      default: begin
        case (req_i.op)
          rpn_pkg::ALU_ADD: begin
            add_a = {{2{req_i.left[DW-1]}}, req_i.left};
            add_b = {{2{req_i.right[DW-1]}}, req_i.right};
          end
          rpn_pkg::ALU_SUB: begin
            add_a   = {{2{req_i.left[DW-1]}}, req_i.left};
            add_b   = {{2{req_i.right[DW-1]}}, req_i.right};
            add_sub = 1'b1;
          end
          rpn_pkg::ALU_NEG: begin
            add_b   = {{2{req_i.right[DW-1]}}, req_i.right};
            add_sub = 1'b1;
          end
          default: ;
        endcase
      end
    endcase
    add_sum = add_a + (add_sub ? ~add_b : add_b) + AW'(add_sub);
  end

  // clip of the exact sum
  assign add_fits = (&add_sum[AW-1:DW-1]) | ~(|add_sum[AW-1:DW-1]);
  assign add_clip = add_fits ? rpn_pkg::data_t'(add_sum[DW-1:0])
                  : (add_sum[AW-1] ? rpn_pkg::Q_MIN : rpn_pkg::Q_MAX);

  // product scaled back, floor rounding, then clip
  assign mul_sh   = prod_q >>> rpn_pkg::FRAC_BITS;
  assign mul_fits = (&mul_sh[2*DW-1:DW-1]) | ~(|mul_sh[2*DW-1:DW-1]);
  assign mul_clip = mul_fits ? rpn_pkg::data_t'(mul_sh[DW-1:0])
                  : (mul_sh[2*DW-1] ? rpn_pkg::Q_MIN : rpn_pkg::Q_MAX);

  // operand magnitudes for the divider
  assign mag_l = req_i.left[DW-1]  ? (~req_i.left + 1'b1)  : req_i.left;
  assign mag_r = req_i.right[DW-1] ? (~req_i.right + 1'b1) : req_i.right;

  assign trial_neg = add_sum[AW-1];

  // quotient range check: up to 2^31 is fine when negative
  assign q_ext = {1'b0, dq_q};
  assign q_sat = neg_q ? ((|q_ext[QW:DW]) | (q_ext[DW-1] & (|q_ext[DW-2:0])))
                       : (|q_ext[QW:DW-1]);

  // phase sequencing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (phase_q)
        PH_IDLE: begin
          if (req_i.start) begin
            case (req_i.op)
              rpn_pkg::ALU_MUL: phase_q <= PH_MUL;
              rpn_pkg::ALU_DIV: begin
                if (req_i.right == '0) begin
                  done_q <= 1'b1;
                end else begin
                  phase_q <= PH_DIV;
                  cnt_q   <= rpn_pkg::DIV_CNT_W'(QW - 1);
                end
              end
              default: done_q <= 1'b1;
            endcase
          end
        end
        PH_MUL: begin
          phase_q <= PH_IDLE;
          done_q  <= 1'b1;
        end
        PH_DIV: begin
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == '0) begin
            phase_q <= PH_FIX;
          end
        end
        PH_FIX: begin
          phase_q <= PH_IDLE;
          done_q  <= 1'b1;
        end
        default: phase_q <= PH_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (phase_q)
      PH_IDLE: begin
        if (req_i.start) begin
          case (req_i.op)
            rpn_pkg::ALU_MUL: prod_q <= req_i.left * req_i.right;
            rpn_pkg::ALU_DIV: begin
              if (req_i.right == '0) begin
                res_q <= req_i.left[DW-1] ? rpn_pkg::Q_MIN : rpn_pkg::Q_MAX;
                sat_q <= 1'b0;
                dz_q  <= 1'b1;
              end else begin
                rem_q <= '0;
                dq_q  <= QW'(mag_l) << rpn_pkg::FRAC_BITS;
                mb_q  <= mag_r;
                neg_q <= req_i.left[DW-1] ^ req_i.right[DW-1];
              end
            end
            default: begin
              res_q <= add_clip;
              sat_q <= ~add_fits;
              dz_q  <= 1'b0;
            end
          endcase
        end
      end
      PH_MUL: begin
        res_q <= mul_clip;
        sat_q <= ~mul_fits;
        dz_q  <= 1'b0;
      end
      PH_DIV: begin
        // restoring step: one quotient bit per cycle
        rem_q <= trial_neg ? {rem_q[DW-2:0], dq_q[QW-1]} : add_sum[DW-1:0];
        dq_q  <= {dq_q[QW-2:0], ~trial_neg};
      end
      PH_FIX: begin
        res_q <= q_sat ? (neg_q ? rpn_pkg::Q_MIN : rpn_pkg::Q_MAX)
                       : rpn_pkg::data_t'(add_sum[DW-1:0]);
        sat_q <= q_sat;
        dz_q  <= 1'b0;
      end
      default: ;
    endcase
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.result   = res_q;
  assign rsp_o.sat      = sat_q;
  assign rsp_o.div_zero = dz_q;

endmodule

@@ src/rpn_ctrl.sv @@
`timescale 1ns / 1ps

module rpn_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  rpn_cmd_if.sink            cmd_if,
  rpn_res_if.source          res_if,
  output rpn_pkg::alu_req_t  alu_req_o,
  input  rpn_pkg::alu_rsp_t  alu_rsp_i,
  output rpn_pkg::mem_req_t  mem_req_o,
  input  rpn_pkg::data_t     mem_rdata_i
);

  localparam int SW = rpn_pkg::SP_W;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_READ  = 5'b00010,
    S_START = 5'b00100,
    S_WAIT  = 5'b01000,
    S_DONE  = 5'b10000
  } state_e;

  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_PUSH,
    ACT_UNARY,
    ACT_BINARY
  } act_e;

  state_e              state_q;
  logic [SW-1:0]       sp_q;
  logic                out_valid_q;
  rpn_pkg::cmd_t       cmd_q;
  rpn_pkg::data_t      val_q;
  act_e                act_q;
  rpn_pkg::status_t    status_q;
  rpn_pkg::data_t      res_q;
  rpn_pkg::data_t      top_q;
  rpn_pkg::data_t      out_top_q;
  rpn_pkg::depth_t     out_depth_q;
  rpn_pkg::status_t    out_status_q;

  state_e              dec_state;
  act_e                dec_act;
  rpn_pkg::status_t    dec_status;
  logic                done_go;
  logic [SW-1:0]       sp_m1;
  logic [SW-1:0]       sp_m2;
  logic [SW-1:0]       sp_new;
  rpn_pkg::data_t      top_new;
  rpn_pkg::alu_op_e    alu_op;

  // command decode at accept
  always_comb begin
    dec_state  = S_DONE;
    dec_act    = ACT_NONE;
    dec_status = rpn_pkg::ST_OK;
    unique case (cmd_if.command) inside
      rpn_pkg::CMD_PUSH: begin
        if (sp_q >= SW'(rpn_pkg::STACK_DEPTH)) begin
          dec_status = rpn_pkg::ST_FULL;
        end else begin
          dec_act = ACT_PUSH;
        end
      end
      rpn_pkg::CMD_NEG: begin
        if (sp_q == '0) begin
          dec_status = rpn_pkg::ST_UNDERFLOW;
        end else begin
          dec_act   = ACT_UNARY;
          dec_state = S_START;
        end
      end
      rpn_pkg::CMD_ADD, rpn_pkg::CMD_SUB, rpn_pkg::CMD_MUL, rpn_pkg::CMD_DIV: begin
        if (sp_q < SW'(2)) begin
          dec_status = rpn_pkg::ST_UNDERFLOW;
        end else begin
          dec_act   = ACT_BINARY;
          dec_state = S_READ;
        end
      end
      default: ;
    endcase
  end

  // operation for the arithmetic unit
  always_comb begin
    unique case (cmd_q)
      rpn_pkg::CMD_ADD: alu_op = rpn_pkg::ALU_ADD;
      rpn_pkg::CMD_SUB: alu_op = rpn_pkg::ALU_SUB;
      rpn_pkg::CMD_MUL: alu_op = rpn_pkg::ALU_MUL;
      rpn_pkg::CMD_DIV: alu_op = rpn_pkg::ALU_DIV;
      default:          alu_op = rpn_pkg::ALU_NEG;
    endcase
  end

  assign sp_m1   = sp_q - SW'(1);
  assign sp_m2   = sp_q - SW'(2);
  assign done_go = (state_q == S_DONE) && (!out_valid_q || res_if.ready);

  // stack after the step
  always_comb begin
    case (act_q)
      ACT_PUSH: begin
        sp_new  = sp_q + SW'(1);
        top_new = val_q;
      end
      ACT_UNARY: begin
        sp_new  = sp_q;
        top_new = res_q;
      end
      ACT_BINARY: begin
        sp_new  = sp_m1;
        top_new = res_q;
      end
      default: begin
        sp_new  = sp_q;
        top_new = top_q;
      end
    endcase
  end

  // memory port: left operand read, write-back at finish
  always_comb begin
    mem_req_o.re    = (state_q == S_READ);
    mem_req_o.raddr = sp_m2[rpn_pkg::ADDR_W-1:0];
    mem_req_o.we    = done_go && (act_q != ACT_NONE);
    mem_req_o.wdata = (act_q == ACT_PUSH) ? val_q : res_q;
    case (act_q)
      ACT_PUSH:  mem_req_o.waddr = sp_q[rpn_pkg::ADDR_W-1:0];
      ACT_UNARY: mem_req_o.waddr = sp_m1[rpn_pkg::ADDR_W-1:0];
      default:   mem_req_o.waddr = sp_m2[rpn_pkg::ADDR_W-1:0];
    endcase
  end

  // top of stack is kept in a register, so only the left operand is read
  assign alu_req_o.start = (state_q == S_START);
  assign alu_req_o.op    = alu_op;
  assign alu_req_o.left  = mem_rdata_i;
  assign alu_req_o.right = top_q;

  // sequencer and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sp_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (done_go) begin
        out_valid_q <= 1'b1;
      end else if (res_if.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE:  if (cmd_if.valid) state_q <= dec_state;
        S_READ:  state_q <= S_START;
        S_START: state_q <= S_WAIT;
        S_WAIT:  if (alu_rsp_i.done) state_q <= S_DONE;
        S_DONE: begin
          if (done_go) begin
            state_q <= S_IDLE;
            sp_q    <= sp_new;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // item and result registers
  always_ff @(posedge clk_i) begin
    if ((state_q == S_IDLE) && cmd_if.valid) begin
      cmd_q    <= cmd_if.command;
      val_q    <= cmd_if.value;
      act_q    <= dec_act;
      status_q <= dec_status;
    end
    if ((state_q == S_WAIT) && alu_rsp_i.done) begin
      res_q    <= alu_rsp_i.result;
      status_q <= alu_rsp_i.div_zero ? rpn_pkg::ST_DIVZERO
                : (alu_rsp_i.sat ? rpn_pkg::ST_SAT : rpn_pkg::ST_OK);
    end
    if (done_go) begin
      top_q        <= top_new;
      out_top_q    <= (sp_new == '0) ? '0 : top_new;
      out_depth_q  <= rpn_pkg::DEPTH_W'(sp_new);
      out_status_q <= status_q;
    end
  end

  assign cmd_if.ready     = (state_q == S_IDLE);
  assign res_if.valid     = out_valid_q;
  assign res_if.top_value = out_top_q;
  assign res_if.depth     = out_depth_q;
  assign res_if.status    = out_status_q;

endmodule

@@ src/rpn_stack_calculator_unit.sv @@
`timescale 1ns / 1ps
// channel   dir  word fields
// cmd_if    in   command[2:0], value[31:0] signed q16.16
// res_if    out  top_value[31:0] signed q16.16, depth[6:0], status[2:0]
//
// divide works one quotient bit per cycle over 48 bits in the shared arithmetic unit;
// a divide by zero skips that bit loop.
// reset clears the stack pointer and the sequencer; the stack memory needs no clearing.
// a new word is taken while a result waits in the output register; that next
// result is held back until the output register has been read.

`include "assert_macros.svh"

module rpn_stack_calculator_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  rpn_cmd_if.sink    cmd_if,
  rpn_res_if.source  res_if
);

  rpn_pkg::alu_req_t alu_req;
  rpn_pkg::alu_rsp_t alu_rsp;
  rpn_pkg::mem_req_t mem_req;
  rpn_pkg::data_t    mem_rdata;

  // sequencer
  rpn_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_if      (cmd_if),
    .res_if      (res_if),
    .alu_req_o   (alu_req),
    .alu_rsp_i   (alu_rsp),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata)
  );

  // shared arithmetic unit
  rpn_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .rsp_o  (alu_rsp)
  );

  // stack storage
  rpn_stack_mem u_mem (
    .clk_i     (clk_i),
    .mem_req_i (mem_req),
    .rdata_o   (mem_rdata)
  );

  // checks
  `ASSERT_PROP(a_depth_range, clk_i, rst_ni, res_if.valid |-> (res_if.depth <= rpn_pkg::DEPTH_W'(rpn_pkg::STACK_DEPTH)))
  `ASSERT_PROP(a_clip_top, clk_i, rst_ni, (res_if.valid && (res_if.status == rpn_pkg::ST_SAT || res_if.status == rpn_pkg::ST_DIVZERO)) |-> (res_if.top_value == rpn_pkg::Q_MAX || res_if.top_value == rpn_pkg::Q_MIN))
  `ASSERT_NEVER(a_alu_overlap, clk_i, rst_ni, alu_req.start && alu_rsp.done)
  `ASSERT_PROP(a_write_posts, clk_i, rst_ni, mem_req.we |=> res_if.valid)

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import rpn_pkg::*;

  localparam int CLK_HALF          = 5;
  localparam int RESET_CYCLES      = 8;
  localparam int IDLE_PCT          = 14;
  localparam int RANDOM_WORDS      = 1925;
  localparam int PAUSE_AT          = 1000;
  localparam int STEADY_FROM       = 1100;
  localparam int STEADY_TO         = 1400;
  localparam int LONG_HOLD_AT      = 400;
  localparam int LONG_HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES      = 64;
  localparam int CYCLE_LIMIT       = 1_000_000;
  localparam int REPORT_LIMIT      = 10;

  // command codes the block leaves alone
  localparam cmd_t CMD_SPARE_LO = cmd_t'(6);
  localparam cmd_t CMD_SPARE_HI = cmd_t'(7);

  // shape of a random run of commands
  typedef enum int {RUN_FILL, RUN_DRAIN, RUN_MIXED, RUN_NOISE} run_kind_e;

  typedef struct {
    data_t   top_value;
    depth_t  depth;
    status_t status;
  } calc_result_t;

  // stack model plus queue of predicted result words
  class calc_scoreboard;
    data_t        stack_words [STACK_DEPTH];
    int unsigned  entries;
    bit           clipped;
    calc_result_t predicted_results [$];
    int           fault_count;

    function new();
      entries     = 0;
      fault_count = 0;
    endfunction

    function int pending();
      return predicted_results.size();
    endfunction

    // clip a wide result to 32 bits and remember whether it was clipped
    function data_t clamp_word(longint x);
      if (x > longint'(Q_MAX)) begin
        clipped = 1'b1;
        return Q_MAX;
      end
      if (x < longint'(Q_MIN)) begin
        clipped = 1'b1;
        return Q_MIN;
      end
      return data_t'(x);
    endfunction

    // apply one accepted command word to the stack model
    function void note_command(cmd_t cmd, data_t value);
      calc_result_t r;
      data_t        lhs;
      data_t        rhs;
      data_t        res;
      longint       mag_l;
      longint       mag_r;
      longint       quot;
      r.status = ST_OK;
      clipped  = 1'b0;
      case (cmd)
        CMD_PUSH: begin
          if (entries >= STACK_DEPTH) begin
            r.status = ST_FULL;
          end else begin
            stack_words[entries] = value;
            entries++;
          end
        end
        CMD_NEG: begin
          if (entries < 1) begin
            r.status = ST_UNDERFLOW;
          end else begin
            stack_words[entries-1] = clamp_word(-longint'(stack_words[entries-1]));
            if (clipped) r.status = ST_SAT;
          end
        end
        CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV: begin
          if (entries < 2) begin
            r.status = ST_UNDERFLOW;
          end else begin
            rhs = stack_words[entries-1];
            lhs = stack_words[entries-2];
            case (cmd)
              CMD_ADD: res = clamp_word(longint'(lhs) + longint'(rhs));
              CMD_SUB: res = clamp_word(longint'(lhs) - longint'(rhs));
              // floor of the product scaled back down
              CMD_MUL: res = clamp_word((longint'(lhs) * longint'(rhs)) >>> FRAC_BITS);
              default: begin
                if (rhs == 0) begin
                  res      = (lhs < 0) ? Q_MIN : Q_MAX;
                  r.status = ST_DIVZERO;
                end else begin
                  // magnitude divide, truncates toward zero
                  mag_l = (lhs < 0) ? -longint'(lhs) : longint'(lhs);
                  mag_r = (rhs < 0) ? -longint'(rhs) : longint'(rhs);
                  quot  = (mag_l << FRAC_BITS) / mag_r;
                  res   = clamp_word(((lhs < 0) != (rhs < 0)) ? -quot : quot);
                end
              end
            endcase
            if (clipped) r.status = ST_SAT;
            entries--;
            stack_words[entries-1] = res;
          end
        end
        default: ;
      endcase
      r.top_value = (entries > 0) ? stack_words[entries-1] : data_t'(0);
      r.depth     = depth_t'(entries);
      predicted_results.insert(predicted_results.size(), r);
    endfunction

    // compare one result word with the oldest prediction
    function void check_result(data_t top_value, depth_t depth, status_t status);
      calc_result_t r;
      if (predicted_results.size() == 0) begin
        fault_count++;
        if (fault_count <= REPORT_LIMIT)
          $display("[%0t] unexpected result word: top %h depth %0d status %0d",
                   $realtime, top_value, depth, status);
        return;
      end
      r = predicted_results.pop_front();
      if (top_value !== r.top_value || depth !== r.depth || status !== r.status) begin
        fault_count++;
        if (fault_count <= REPORT_LIMIT)
          $display("[%0t] result mismatch: expected top %h depth %0d status %0d, got top %h depth %0d status %0d",
                   $realtime, r.top_value, r.depth, r.status, top_value, depth, status);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  rpn_cmd_if cmd_if ();
  rpn_res_if res_if ();

  calc_scoreboard sb = new();

  bit steady_run;
  bit long_hold_done;
  int commands_accepted;
  int hold_left;
  int cycle_count;

  rpn_stack_calculator_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_if (cmd_if),
    .res_if (res_if)
  );

  // clock
  always begin
    #CLK_HALF clk_i = 1'b1;
    #CLK_HALF clk_i = 1'b0;
  end

  // offer one command word, starting and ending at a falling edge
  task automatic send_command(input cmd_t cmd, input data_t value);
    while (!steady_run && $urandom_range(99) < IDLE_PCT) begin
      cmd_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    cmd_if.valid   <= 1'b1;
    cmd_if.command <= cmd;
    cmd_if.value   <= value;
    do @(posedge clk_i); while (!cmd_if.ready);
    sb.note_command(cmd, value);
    commands_accepted++;
    @(negedge clk_i);
  endtask

  // result side: random stalls plus one long hold-off
  initial begin
    res_if.ready = 1'b0;
    hold_left    = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!long_hold_done && commands_accepted >= LONG_HOLD_AT) begin
        hold_left      = LONG_HOLD_CYCLES;
        long_hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else if (!steady_run && $urandom_range(99) < IDLE_PCT) begin
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // sample result words
  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready)
      sb.check_result(res_if.top_value, res_if.depth, res_if.status);
  end

  // run limit
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  // stimulus
  initial begin
    run_kind_e run_kind;
    int        run_left;
    int        push_pct;
    int        small_mag;
    cmd_t      cmd;
    data_t     value;

    cmd_if.valid   = 1'b0;
    cmd_if.command = CMD_PUSH;
    cmd_if.value   = '0;
    rst_ni         = 1'b0;
    steady_run     = 1'b0;
    long_hold_done = 1'b0;
    commands_accepted = 0;
    run_left       = 0;
    run_kind       = RUN_MIXED;

    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: underflow on empty stack, unused codes
    send_command(CMD_ADD, data_t'(0));
    send_command(CMD_NEG, data_t'(0));
    send_command(CMD_SPARE_LO, Q_MAX);
    send_command(CMD_SPARE_HI, Q_MIN);
    // underflow with one entry, add and subtract saturation
    send_command(CMD_PUSH, Q_MAX);
    send_command(CMD_SUB, data_t'(0));
    send_command(CMD_PUSH, data_t'(1));
    send_command(CMD_ADD, data_t'(0));
    send_command(CMD_PUSH, Q_MIN);
    send_command(CMD_SUB, data_t'(0));
    send_command(CMD_NEG, data_t'(0));
    // negate of the most negative value saturates, then a clipped product
    send_command(CMD_PUSH, Q_MIN);
    send_command(CMD_NEG, data_t'(0));
    send_command(CMD_MUL, data_t'(0));
    // divide by zero with negative, then zero dividend
    send_command(CMD_PUSH, data_t'(0));
    send_command(CMD_DIV, data_t'(0));
    send_command(CMD_PUSH, data_t'(0));
    send_command(CMD_PUSH, data_t'(0));
    send_command(CMD_DIV, data_t'(0));
    // negative product rounds down, quotients truncate
    send_command(CMD_PUSH, data_t'(32'hFFFF_FFFF));
    send_command(CMD_PUSH, data_t'(1));
    send_command(CMD_MUL, data_t'(0));
    send_command(CMD_PUSH, data_t'(32'hFFFD_0000));
    send_command(CMD_DIV, data_t'(0));
    send_command(CMD_DIV, data_t'(0));
    send_command(CMD_DIV, data_t'(0));

    // random runs: fill to full, drain to underflow, mixed, raw noise
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (run_left == 0) begin
        run_kind = run_kind_e'($urandom_range(3));
        run_left = $urandom_range(20, 120);
      end
      run_left--;
      steady_run = (n >= STEADY_FROM && n < STEADY_TO);

      // let the block empty out once
      if (n == PAUSE_AT) begin
        cmd_if.valid <= 1'b0;
        do @(negedge clk_i); while (sb.pending() != 0);
      end

      case (run_kind)
        RUN_FILL:  push_pct = 85;
        RUN_DRAIN: push_pct = 15;
        default:   push_pct = 50;
      endcase

      if (run_kind == RUN_NOISE) begin
        cmd = cmd_t'($urandom_range(7));
      end else if ($urandom_range(99) < push_pct) begin
        cmd = CMD_PUSH;
      end else if ($urandom_range(99) < 3) begin
        cmd = $urandom_range(1) ? CMD_SPARE_HI : CMD_SPARE_LO;
      end else begin
        case ($urandom_range(4))
          0:       cmd = CMD_ADD;
          1:       cmd = CMD_SUB;
          2:       cmd = CMD_MUL;
          3:       cmd = CMD_DIV;
          default: cmd = CMD_NEG;
        endcase
      end

      // operand mix: zero, extremes, small values, full range
      case ($urandom_range(9))
        0: value = data_t'(0);
        1: begin
          case ($urandom_range(3))
            0:       value = Q_MAX;
            1:       value = Q_MIN;
            2:       value = data_t'(1);
            default: value = data_t'(32'hFFFF_FFFF);
          endcase
        end
        2, 3: begin
          small_mag = $urandom_range(1048576);
          value     = data_t'(small_mag - 524288);
        end
        default: value = data_t'($urandom);
      endcase

      send_command(cmd, value);
    end
    cmd_if.valid <= 1'b0;
    steady_run   = 1'b0;

    // wait out the remaining result words, then a little more
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (sb.fault_count == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+src
src/rpn_pkg.sv
src/rpn_cmd_if.sv
src/rpn_res_if.sv
src/rpn_stack_mem.sv
src/rpn_alu.sv
src/rpn_ctrl.sv
src/rpn_stack_calculator_unit.sv
test/tb_top.sv
